// ===== hdl/rvex_pkg.sv =====
// Package with opcodes, CSR slot indexes and helper functions for the execute stage.
package rvex_pkg;

  localparam int unsigned TagBitsDefault = 4;
  localparam logic [31:0] MisaReset = 32'h4000_1101;
  localparam int unsigned CsrCount = 11;

  typedef enum logic [4:0] {
    OpNull = 5'd0, OpAdd = 5'd1, OpSlt = 5'd2, OpSltu = 5'd3, OpXor = 5'd4,
    OpOr = 5'd5, OpAnd = 5'd6, OpSll = 5'd7, OpSrl = 5'd8, OpSra = 5'd9,
    OpSub = 5'd10, OpSlli = 5'd11, OpSrli = 5'd12, OpSrai = 5'd13, OpLui = 5'd14,
    OpAuipc = 5'd15, OpJal = 5'd16, OpMul = 5'd17, OpMulh = 5'd18,
    OpMulhsu = 5'd19, OpMulhu = 5'd20, OpDiv = 5'd21, OpDivu = 5'd22,
    OpRem = 5'd23, OpRemu = 5'd24, OpCsrrw = 5'd25, OpCsrrs = 5'd26,
    OpCsrrc = 5'd27, OpCsrrwi = 5'd28, OpCsrrsi = 5'd29, OpCsrrci = 5'd30,
    OpBad = 5'd31
  } op_e;

  typedef enum logic [1:0] {
    SrcRs2 = 2'd0, SrcImmI = 2'd1, SrcImmS = 2'd2, SrcImmU = 2'd3
  } src_e;

  localparam logic [3:0] CiUstatus = 4'd0;
  localparam logic [3:0] CiMstatus = 4'd1;
  localparam logic [3:0] CiMisa = 4'd2;
  localparam logic [3:0] CiMtvec = 4'd3;
  localparam logic [3:0] CiMepc = 4'd4;
  localparam logic [3:0] CiMcause = 4'd5;
  localparam logic [3:0] CiMarchid = 4'd6;
  localparam logic [3:0] CiMimpid = 4'd7;
  localparam logic [3:0] CiMhartid = 4'd8;
  localparam logic [3:0] CiMinstret = 4'd9;
  localparam logic [3:0] CiMcycle = 4'd10;

  // Datapath command from the controller.
  typedef struct packed {
    logic load;
    logic mul_start;
    logic div_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_div;
    logic is_mul;
    logic div_last;
  } ctl_sts_t;

  function automatic logic [3:0] csr_slot(input logic [11:0] addr);
    logic [3:0] s;
    unique case (addr)
      12'h000: s = CiUstatus;
      12'h300: s = CiMstatus;
      12'h301: s = CiMisa;
      12'h305: s = CiMtvec;
      12'h341: s = CiMepc;
      12'h342: s = CiMcause;
      12'hB00: s = CiMcycle;
      12'hF12: s = CiMarchid;
      12'hF13: s = CiMimpid;
      12'hB02: s = CiMinstret;
      12'hF14: s = CiMhartid;
      default: s = CiMarchid;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/rv32im_execute_alu_csr.sv =====
// Top level of the RV32IM execute stage with machine CSR file.
// One decoded instruction enters on the s_axis channel and one result item
// leaves on the m_axis channel for each of them, in order.
// An item is taken when tvalid and tready are both high on a channel.
// Simple ALU and CSR instructions register their result in the decode state,
// multiplies go through one registered 33x33 product stage, and divides go
// through a radix-2 restoring divider that retires one quotient bit a cycle,
// followed by a state that registers the result. The next item is
// accepted in the cycle its predecessor's result is taken, so an item is
// never accepted before the result of the previous one has left.
// While the receiver holds m_axis_tready low, the result stays on the port
// and no new item is accepted. Reset clears the controller and the CSR file
// (misa resets to 0x40001101, all others to zero); the block is ready for
// an item in the first cycle after reset is released.
module rv32im_execute_alu_csr import rvex_pkg::*; #(
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op, operand_src, rs1_value, rs2_value, imm20, pc_value, rd_index, reg_write,
  // mem_to_reg, load_kind, store_kind, tag; zero padded.
  input  logic [(135+TAG_BITS+7)/8*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // alu_result, store_data, word_address, mem_access, write_enable, load_to_reg,
  // load_type, store_type, write_reg, result_tag; zero padded.
  output logic [(107+TAG_BITS+7)/8*8-1:0] m_axis_tdata
);

  localparam int unsigned OutW = (107 + TAG_BITS + 7) / 8 * 8;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic in_fire, out_fire;
  logic [31:0] res, sd;
  logic [4:0] rd;
  logic rw, m2r;
  logic [2:0] ld;
  logic [1:0] st;
  logic [TAG_BITS-1:0] tg;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  rvex_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_fire_i(out_fire),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  rvex_dp #(.TagBits(TAG_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[4:0]), .src_i(s_axis_tdata[6:5]),
    .rs1_i(s_axis_tdata[38:7]), .rs2_i(s_axis_tdata[70:39]),
    .imm_i(s_axis_tdata[90:71]), .pc_i(s_axis_tdata[122:91]),
    .rd_i(s_axis_tdata[127:123]), .rw_i(s_axis_tdata[128]),
    .m2r_i(s_axis_tdata[129]), .ld_i(s_axis_tdata[132:130]),
    .st_i(s_axis_tdata[134:133]), .tag_i(s_axis_tdata[135+:TAG_BITS]),
    .res_o(res), .store_o(sd), .rd_o(rd), .rw_o(rw), .m2r_o(m2r),
    .ld_o(ld), .st_o(st), .tag_o(tg)
  );

  assign m_axis_tdata = OutW'({tg, rd, st, ld, m2r, rw, (ld != 3'd0) || (st != 2'd0),
                               res[31:2], sd, res});

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("accepted while result pending");
  a_one_hot_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mul_start, cmd.div_step, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== hdl/rvex_ctrl.sv =====
// Controller state machine that sequences load, multiply, divide and output.
module rvex_ctrl import rvex_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     out_fire_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o,
  output logic     in_ready_o,
  output logic     out_valid_o
);

  typedef enum logic [2:0] {
    StIdle, StDecode, StMul, StDiv, StDivDone, StOut
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == StIdle) || (state_q == StOut && out_fire_i);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_fire_i;
    unique case (state_q)
      StDecode: begin
        cmd_o.mul_start = sts_i.is_mul;
        cmd_o.finish    = !sts_i.is_mul && !sts_i.is_div;
      end
      StMul:     cmd_o.finish = 1'b1;
      StDiv:     cmd_o.div_step = 1'b1;
      StDivDone: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle:   if (in_fire_i) state_q <= StDecode;
        StDecode: begin
          if (sts_i.is_mul) state_q <= StMul;
          else if (sts_i.is_div) state_q <= StDiv;
          else state_q <= StOut;
        end
        StMul:     state_q <= StOut;
        StDiv:     if (sts_i.div_last) state_q <= StDivDone;
        StDivDone: state_q <= StOut;
        StOut: begin
          if (in_fire_i) state_q <= StDecode;
          else if (out_fire_i) state_q <= StIdle;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hdl/rvex_dp.sv =====
// Datapath with operand select, ALU, multiplier, serial divider and CSR file.
module rvex_dp import rvex_pkg::*; #(
  parameter int unsigned TagBits = TagBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_cmd_t           cmd_i,
  output ctl_sts_t           sts_o,
  input  logic [4:0]         op_i,
  input  logic [1:0]         src_i,
  input  logic [31:0]        rs1_i,
  input  logic [31:0]        rs2_i,
  input  logic [19:0]        imm_i,
  input  logic [31:0]        pc_i,
  input  logic [4:0]         rd_i,
  input  logic               rw_i,
  input  logic               m2r_i,
  input  logic [2:0]         ld_i,
  input  logic [1:0]         st_i,
  input  logic [TagBits-1:0] tag_i,
  output logic [31:0]        res_o,
  output logic [31:0]        store_o,
  output logic [4:0]         rd_o,
  output logic               rw_o,
  output logic               m2r_o,
  output logic [2:0]         ld_o,
  output logic [1:0]         st_o,
  output logic [TagBits-1:0] tag_o
);

  op_e          op_q;
  logic [1:0]   src_q;
  logic [31:0]  a_q, rs2_q, pc_q, b, res_q, res_d;
  logic [19:0]  imm_q;
  logic [4:0]   rd_q, sh;
  logic         rw_q, m2r_q;
  logic [2:0]   ld_q;
  logic [1:0]   st_q;
  logic [TagBits-1:0] tag_q;
  logic [31:0]  csr_q [CsrCount];
  logic [31:0]  csr_d [CsrCount];
  logic [65:0]  prod_q;
  logic [32:0]  ma, mb;
  logic [31:0]  dq_q, dr_q, ua, ub;
  logic [4:0]   dcnt_q;
  logic [32:0]  trial;
  logic         neg_q, sgn_div;
  logic [3:0]   slot;
  logic [31:0]  csr_old, csr_v, csr_new, mcyc_inc, quo, rem;
  logic         nop, csr_wr;

  always_comb begin
    unique case (src_e'(src_q))
      SrcRs2:  b = rs2_q;
      SrcImmI: b = {{20{imm_q[19]}}, imm_q[19:8]};
      SrcImmS: b = {{20{imm_q[19]}}, imm_q[19:13], rd_q};
      default: b = {imm_q, 12'd0};
    endcase
  end
  assign sh = b[4:0];

  assign sts_o.is_mul   = (op_q == OpMul) || (op_q == OpMulh) ||
                          (op_q == OpMulhsu) || (op_q == OpMulhu);
  assign sts_o.is_div   = (op_q == OpDiv) || (op_q == OpDivu) ||
                          (op_q == OpRem) || (op_q == OpRemu);
  assign sts_o.div_last = (dcnt_q == 5'd31);

  assign ma = {(op_q == OpMulh || op_q == OpMulhsu) & a_q[31], a_q};
  assign mb = {(op_q == OpMulh) & b[31], b};

  assign sgn_div = (op_q == OpDiv) || (op_q == OpRem);
  assign ua = (sgn_div && a_q[31]) ? 32'd0 - a_q : a_q;
  assign ub = (sgn_div && b[31]) ? 32'd0 - b : b;
  assign trial = {dr_q, dq_q[31]} - {1'b0, ub};

  assign slot     = csr_slot(imm_q[19:8]);
  assign mcyc_inc = csr_q[CiMcycle] + 32'd1;
  assign csr_old  = (slot == CiMcycle) ? mcyc_inc : csr_q[slot];
  assign csr_v    = (op_q >= OpCsrrwi) ? {27'd0, imm_q[7:3]} : a_q;
  always_comb begin
    if (op_q == OpCsrrw || op_q == OpCsrrwi) csr_new = csr_v;
    else if (op_q == OpCsrrs || op_q == OpCsrrsi) csr_new = csr_old | csr_v;
    else csr_new = csr_old & ~csr_v;
  end
  assign nop = (op_q == OpNull) && !rw_q && (ld_q == 3'd0) && (st_q == 2'd0);
  assign csr_wr = (op_q >= OpCsrrw) && (op_q <= OpCsrrci) && (imm_q[19:18] != 2'b11);

  // The cycle counter advances first, then the CSR write, then retirement.
  always_comb begin
    for (int i = 0; i < CsrCount; i++) csr_d[i] = csr_q[i];
    csr_d[CiMcycle] = mcyc_inc;
    if (csr_wr) csr_d[slot] = csr_new;
    if (!nop) csr_d[CiMinstret] = csr_d[CiMinstret] + 32'd1;
  end

  always_comb begin
    quo = neg_q ? 32'd0 - dq_q : dq_q;
    rem = (sgn_div && a_q[31]) ? 32'd0 - dr_q : dr_q;
    if (b == 32'd0) begin
      quo = '1;
      rem = a_q;
    end
  end

  always_comb begin
    res_d = res_q;
    unique case (op_q)
      OpAdd:   res_d = a_q + b;
      OpSlt:   res_d = {31'd0, $signed(a_q) < $signed(b)};
      OpSltu:  res_d = {31'd0, a_q < b};
      OpXor:   res_d = a_q ^ b;
      OpOr:    res_d = a_q | b;
      OpAnd:   res_d = a_q & b;
      OpSll, OpSlli: res_d = a_q << sh;
      OpSrl, OpSrli: res_d = a_q >> sh;
      OpSra, OpSrai: res_d = 32'($signed(a_q) >>> sh);
      OpSub:   res_d = a_q - b;
      OpLui:   res_d = b;
      OpAuipc: res_d = b + pc_q;
      OpJal:   res_d = pc_q + 32'd4;
      OpMul:   res_d = prod_q[31:0];
      OpMulh, OpMulhsu, OpMulhu: res_d = prod_q[63:32];
      OpDiv, OpDivu: res_d = quo;
      OpRem, OpRemu: res_d = rem;
      OpCsrrw, OpCsrrs, OpCsrrc, OpCsrrwi, OpCsrrsi, OpCsrrci: res_d = csr_old;
      default: res_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(op_i); src_q <= src_i; a_q <= rs1_i; rs2_q <= rs2_i;
      imm_q <= imm_i; pc_q <= pc_i; rd_q <= rd_i; rw_q <= rw_i;
      m2r_q <= m2r_i; ld_q <= ld_i; st_q <= st_i; tag_q <= tag_i;
    end
    if (cmd_i.mul_start) prod_q <= 66'($signed(ma) * $signed(mb));
    if (cmd_i.div_step) begin
      dq_q <= {dq_q[30:0], !trial[32]};
      dr_q <= trial[32] ? {dr_q[30:0], dq_q[31]} : trial[31:0];
    end else begin
      dq_q <= ua;
      dr_q <= '0;
      neg_q <= sgn_div && (a_q[31] ^ b[31]);
    end
    if (cmd_i.finish) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      for (int i = 0; i < CsrCount; i++) begin
        csr_q[i] <= (i == int'(CiMisa)) ? MisaReset : 32'd0;
      end
    end else begin
      dcnt_q <= cmd_i.div_step ? dcnt_q + 5'd1 : 5'd0;
      if (cmd_i.finish) begin
        for (int i = 0; i < CsrCount; i++) csr_q[i] <= csr_d[i];
      end
    end
  end

  assign res_o = res_q;
  assign store_o = rs2_q;
  assign rd_o = rd_q;
  assign rw_o = rw_q;
  assign m2r_o = m2r_q;
  assign ld_o = ld_q;
  assign st_o = st_q;
  assign tag_o = tag_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the RV32IM execute stage with its machine CSR file.
`timescale 1ns / 100ps

module tb;
  import rvex_pkg::*;

  localparam int unsigned TagW = 4;
  localparam int unsigned InW = (135 + TagW + 7) / 8 * 8;
  localparam int unsigned OutW = (107 + TagW + 7) / 8 * 8;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [1:0] store_kind;
    logic [2:0] load_kind;
    logic mem_to_reg;
    logic reg_write;
    logic [4:0] rd_index;
    logic [31:0] pc_value;
    logic [19:0] imm20;
    logic [31:0] rs2_value;
    logic [31:0] rs1_value;
    src_e operand_src;
    op_e op;
  } instr_t;

  typedef struct packed {
    logic [TagW-1:0] result_tag;
    logic [4:0] write_reg;
    logic [1:0] store_type;
    logic [2:0] load_type;
    logic load_to_reg;
    logic write_enable;
    logic mem_access;
    logic [29:0] word_address;
    logic [31:0] store_data;
    logic [31:0] alu_result;
  } exec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  logic [31:0] csr_model [CsrCount];
  exec_res_t expected_q[$];
  int errors = 0;

  rv32im_execute_alu_csr #(.TAG_BITS(TagW)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [3:0] slot_of(logic [11:0] addr);
    case (addr)
      12'h000: return CiUstatus;
      12'h300: return CiMstatus;
      12'h301: return CiMisa;
      12'h305: return CiMtvec;
      12'h341: return CiMepc;
      12'h342: return CiMcause;
      12'hB00: return CiMcycle;
      12'hF12: return CiMarchid;
      12'hF13: return CiMimpid;
      12'hB02: return CiMinstret;
      12'hF14: return CiMhartid;
      default: return CiMarchid;
    endcase
  endfunction

  function automatic exec_res_t execute(instr_t t);
    exec_res_t r;
    logic [31:0] a, b, res, v;
    logic signed [63:0] p;
    logic [63:0] u;
    logic [3:0] sl;
    logic [4:0] sh;
    csr_model[CiMcycle] = csr_model[CiMcycle] + 1;
    a = t.rs1_value;
    case (t.operand_src)
      SrcRs2: b = t.rs2_value;
      SrcImmI: b = {{20{t.imm20[19]}}, t.imm20[19:8]};
      SrcImmS: b = {{20{t.imm20[19]}}, t.imm20[19:13], t.rd_index};
      default: b = {t.imm20, 12'h000};
    endcase
    sh = b[4:0];
    res = '0;
    case (t.op)
      OpAdd: res = a + b;
      OpSlt: res = {31'd0, $signed(a) < $signed(b)};
      OpSltu: res = {31'd0, a < b};
      OpXor: res = a ^ b;
      OpOr: res = a | b;
      OpAnd: res = a & b;
      OpSll, OpSlli: res = a << sh;
      OpSrl, OpSrli: res = a >> sh;
      OpSra, OpSrai: res = $signed(a) >>> sh;
      OpSub: res = a - b;
      OpLui: res = b;
      OpAuipc: res = b + t.pc_value;
      OpJal: res = t.pc_value + 32'd4;
      OpMul: res = a * b;
      OpMulh: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        res = p[63:32];
      end
      OpMulhsu: begin
        p = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
        res = p[63:32];
      end
      OpMulhu: begin
        u = {32'd0, a} * {32'd0, b};
        res = u[63:32];
      end
      OpDiv: begin
        if (b == 0) res = '1;
        else if (a == 32'h8000_0000 && b == '1) res = a;
        else res = $signed(a) / $signed(b);
      end
      OpDivu: res = (b == 0) ? '1 : a / b;
      OpRem: begin
        if (b == 0) res = a;
        else if (a == 32'h8000_0000 && b == '1) res = '0;
        else res = $signed(a) % $signed(b);
      end
      OpRemu: res = (b == 0) ? a : a % b;
      OpCsrrw, OpCsrrs, OpCsrrc, OpCsrrwi, OpCsrrsi, OpCsrrci: begin
        sl = slot_of(t.imm20[19:8]);
        v = (t.op >= OpCsrrwi) ? {27'd0, t.imm20[7:3]} : a;
        res = csr_model[sl];
        if (t.imm20[19:18] != 2'b11) begin
          case (t.op)
            OpCsrrw, OpCsrrwi: csr_model[sl] = v;
            OpCsrrs, OpCsrrsi: csr_model[sl] = csr_model[sl] | v;
            default: csr_model[sl] = csr_model[sl] & ~v;
          endcase
        end
      end
      default: res = '0;
    endcase
    if (!(t.op == OpNull && !t.reg_write && t.load_kind == 0 && t.store_kind == 0))
      csr_model[CiMinstret] = csr_model[CiMinstret] + 1;
    r.alu_result = res;
    r.store_data = t.rs2_value;
    r.word_address = res[31:2];
    r.mem_access = (t.load_kind != 0) || (t.store_kind != 0);
    r.write_enable = t.reg_write;
    r.load_to_reg = t.mem_to_reg;
    r.load_type = t.load_kind;
    r.store_type = t.store_kind;
    r.write_reg = t.rd_index;
    r.result_tag = t.tag;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic instr_t random_instr();
    instr_t t;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    t = instr_t'(raw[$bits(instr_t)-1:0]);
    t.op = op_e'($urandom_range(0, 31));
    t.operand_src = src_e'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: t.rs1_value = 32'h8000_0000;
      1: t.rs1_value = '1;
      2: t.rs1_value = $urandom_range(0, 9);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: t.rs2_value = '0;
      1: t.rs2_value = '1;
      2: t.rs2_value = $urandom_range(0, 9);
      default: ;
    endcase
    if (t.op >= OpCsrrw && t.op <= OpCsrrci && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 10))
        0: t.imm20[19:8] = 12'h000;
        1: t.imm20[19:8] = 12'h300;
        2: t.imm20[19:8] = 12'h301;
        3: t.imm20[19:8] = 12'h305;
        4: t.imm20[19:8] = 12'h341;
        5: t.imm20[19:8] = 12'h342;
        6: t.imm20[19:8] = 12'hB00;
        7: t.imm20[19:8] = 12'hB02;
        8: t.imm20[19:8] = 12'hF12;
        9: t.imm20[19:8] = 12'hF13;
        default: t.imm20[19:8] = 12'hF14;
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      t.reg_write = 1'b0;
      t.load_kind = '0;
      t.store_kind = '0;
    end
    return t;
  endfunction

  task automatic send_instr(instr_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata <= InW'(t);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(execute(t));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic instr_t mk(op_e op, src_e src, logic [31:0] a, logic [31:0] b,
                                logic [19:0] imm);
    instr_t t;
    t = '0;
    t.op = op;
    t.operand_src = src;
    t.rs1_value = a;
    t.rs2_value = b;
    t.imm20 = imm;
    t.pc_value = 32'hFFFF_FFFC;
    t.rd_index = 5'd31;
    t.reg_write = 1'b1;
    t.tag = '1;
    return t;
  endfunction

  task automatic test_directed();
    instr_t t;
    send_instr('0);
    send_instr(mk(OpDiv, SrcRs2, 32'h8000_0000, '1, '0));
    send_instr(mk(OpRem, SrcRs2, 32'h8000_0000, '1, '0));
    send_instr(mk(OpDiv, SrcRs2, 32'd7, '0, '0));
    send_instr(mk(OpRemu, SrcRs2, 32'd7, '0, '0));
    send_instr(mk(OpRem, SrcRs2, 32'hFFFF_FFF9, 32'd2, '0));
    send_instr(mk(OpMulh, SrcRs2, 32'h8000_0000, 32'h8000_0000, '0));
    send_instr(mk(OpMulhsu, SrcRs2, '1, '1, '0));
    send_instr(mk(OpSlli, SrcImmI, 32'd1, '0, 20'h3F_F00));
    send_instr(mk(OpSrai, SrcImmI, 32'h8000_0000, '0, 20'h01_F00));
    send_instr(mk(OpSra, SrcRs2, 32'h8000_0000, 32'hFFFF_FFE0, '0));
    send_instr(mk(OpAuipc, SrcImmU, '0, '0, '1));
    send_instr(mk(OpJal, SrcRs2, '0, '0, '0));
    t = mk(OpAdd, SrcImmS, 32'd5, '0, 20'hFE000);
    t.load_kind = 3'd7;
    t.store_kind = 2'd3;
    t.mem_to_reg = 1'b1;
    send_instr(t);
    send_instr(mk(OpCsrrs, SrcRs2, '0, '0, 20'hB0000));
    send_instr(mk(OpCsrrw, SrcRs2, 32'h1234_5678, '0, 20'h30000));
    send_instr(mk(OpCsrrci, SrcRs2, '0, '0, 20'h301F8));
    send_instr(mk(OpCsrrwi, SrcRs2, '0, '0, 20'hF14F8));
    send_instr(mk(OpCsrrsi, SrcRs2, '0, '0, 20'h7AB08));
    send_instr(mk(OpCsrrs, SrcRs2, '0, '0, 20'hB0200));
    send_instr(mk(OpBad, SrcRs2, '1, '1, '1));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_instr(random_instr());
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < CsrCount; i++) csr_model[i] = '0;
    csr_model[CiMisa] = MisaReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(1000);
    wait_drained();
    if (errors == 0) $display("[rv32im_execute_alu_csr] OK");
    else $display("[rv32im_execute_alu_csr] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    exec_res_t got, want;
    int g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = exec_res_t'(m_axis_tdata[$bits(exec_res_t)-1:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%t unexpected result %h", $realtime, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want || m_axis_tdata[OutW-1:$bits(exec_res_t)] !== '0) begin
          errors++;
          $display("%t mismatch: expected %h actual %h", $realtime, want, got);
        end
      end
    end
    g = gap_len();
    m_axis_tready <= (g == 0);
  end

  initial begin
    #2_000_000;
    $display("[rv32im_execute_alu_csr] ERROR");
    $finish;
  end

endmodule
